/* rtl/fpa_pkg.sv */
// fpa_pkg: shared types, opcodes and widths of the fixed-point alu
// no dependencies
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DW = 32;
   localparam int NW = DW + FRAC_BITS;   // width of the shifted dividend magnitude
   localparam int PW = 2 * DW;

   typedef enum logic [3:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_GT      = 4'd4,
      OP_LT      = 4'd5,
      OP_GE      = 4'd6,
      OP_LE      = 4'd7,
      OP_EQ      = 4'd8,
      OP_NE      = 4'd9,
      OP_MIN     = 4'd10,
      OP_MAX     = 4'd11,
      OP_INC     = 4'd12,
      OP_DEC     = 4'd13,
      OP_TOINT   = 4'd14,
      OP_FROMINT = 4'd15
   } op_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   localparam logic [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};

   // one request as it walks down the divider chain
   typedef struct packed {
      op_type          op;
      logic [DW-1:0]   value;
      logic            flag;
      logic [1:0]      status;
      logic [PW-1:0]   prod;
      logic [DW-1:0]   rem;
      logic [NW-1:0]   num;
      logic [DW-1:0]   den;
      logic [NW-1:0]   quo;
      logic            neg;
   } item_type;

   // after rounding, before saturation
   typedef struct packed {
      op_type          op;
      logic [DW-1:0]   value;
      logic            flag;
      logic [1:0]      status;
      logic [PW-1:0]   mag;
      logic            neg;
   } res_type;

endpackage

/* rtl/fpa_front.sv */
// fpa_front: first stage, finishes the simple ops and sets up mul and div
// depends on fpa_pkg
module fpa_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [3:0]               in_op,
   input  logic [fpa_pkg::DW-1:0]   in_a,
   input  logic [fpa_pkg::DW-1:0]   in_b,
   output logic                     out_valid,
   output fpa_pkg::item_type        out_item
);

   localparam int DW = fpa_pkg::DW;
   localparam int F  = fpa_pkg::FRAC_BITS;

   logic                 valid_ff;
   fpa_pkg::item_type    item_ff;
   fpa_pkg::item_type    item_in;
   fpa_pkg::op_type      op;
   logic [DW:0]          sum;
   logic [DW:0]          addend;
   logic                 lt;
   logic [DW-1:0]        abs_a;
   logic [DW-1:0]        abs_b;
   logic [F:0]           top;

   always_comb begin
      op     = fpa_pkg::op_type'(in_op);
      lt     = $signed(in_a) < $signed(in_b);
      abs_a  = in_a[DW-1] ? DW'(-in_a) : in_a;
      abs_b  = in_b[DW-1] ? DW'(-in_b) : in_b;
      top    = in_a[DW-1 -: F+1];
      unique case (op)
         fpa_pkg::OP_SUB: addend = ~{in_b[DW-1], in_b} + (DW+1)'(1);
         fpa_pkg::OP_INC: addend = (DW+1)'(1);
         fpa_pkg::OP_DEC: addend = '1;
         default:         addend = {in_b[DW-1], in_b};
      endcase
      sum = {in_a[DW-1], in_a} + addend;

      item_in        = '0;
      item_in.op     = op;
      item_in.prod   = fpa_pkg::PW'($signed(in_a) * $signed(in_b));
      item_in.num    = {abs_a, {F{1'b0}}};
      item_in.den    = abs_b;
      item_in.neg    = in_a[DW-1] ^ in_b[DW-1];
      item_in.status = fpa_pkg::ST_OK;
      unique case (op)
         fpa_pkg::OP_ADD, fpa_pkg::OP_SUB, fpa_pkg::OP_INC, fpa_pkg::OP_DEC: begin
            if (sum[DW] != sum[DW-1]) begin
               item_in.status = fpa_pkg::ST_OVF;
               item_in.value  = sum[DW] ? fpa_pkg::MIN_VAL : fpa_pkg::MAX_VAL;
            end else begin
               item_in.value = sum[DW-1:0];
            end
         end
         fpa_pkg::OP_MUL: item_in.value = '0;
         fpa_pkg::OP_DIV: begin
            if (in_b == '0) begin
               item_in.status = fpa_pkg::ST_DIV0;
               if (in_a[DW-1])      item_in.value = fpa_pkg::MIN_VAL;
               else if (in_a != '0) item_in.value = fpa_pkg::MAX_VAL;
               else                 item_in.value = '0;
            end
         end
         fpa_pkg::OP_GT:  item_in.flag = !lt && (in_a != in_b);
         fpa_pkg::OP_LT:  item_in.flag = lt;
         fpa_pkg::OP_GE:  item_in.flag = !lt;
         fpa_pkg::OP_LE:  item_in.flag = lt || (in_a == in_b);
         fpa_pkg::OP_EQ:  item_in.flag = in_a == in_b;
         fpa_pkg::OP_NE:  item_in.flag = in_a != in_b;
         fpa_pkg::OP_MIN: item_in.value = lt ? in_a : in_b;
         fpa_pkg::OP_MAX: item_in.value = (!lt && (in_a != in_b)) ? in_a : in_b;
         fpa_pkg::OP_TOINT: item_in.value = DW'($signed(in_a) >>> F);
         fpa_pkg::OP_FROMINT: begin
            // fits only if the bits shifted out all match the sign
            if (top != '0 && top != '1) begin
               item_in.status = fpa_pkg::ST_OVF;
               item_in.value  = in_a[DW-1] ? fpa_pkg::MIN_VAL : fpa_pkg::MAX_VAL;
            end else begin
               item_in.value = in_a << F;
            end
         end
         default: item_in.value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

/* rtl/fpa_cell.sv */
// fpa_cell: one restoring-division step, passes the rest of the request along
// depends on fpa_pkg
module fpa_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  fpa_pkg::item_type    in_item,
   output logic                 out_valid,
   output fpa_pkg::item_type    out_item
);

   localparam int DW = fpa_pkg::DW;
   localparam int NW = fpa_pkg::NW;

   logic                 valid_ff;
   fpa_pkg::item_type    item_ff;
   fpa_pkg::item_type    item_in;
   logic [DW-1:0]        shifted;
   logic                 ge;

   always_comb begin
      // remainder stays below the divisor, so the shifted value fits
      shifted      = {in_item.rem[DW-2:0], in_item.num[NW-1]};
      ge           = shifted >= in_item.den;
      item_in      = in_item;
      item_in.rem  = ge ? shifted - in_item.den : shifted;
      item_in.num  = {in_item.num[NW-2:0], 1'b0};
      item_in.quo  = {in_item.quo[NW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

/* rtl/fpa_back.sv */
// fpa_back: rounds mul and div results, then saturates them to 32 bits
// depends on fpa_pkg
module fpa_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  fpa_pkg::item_type        in_item,
   output logic                     out_valid,
   output logic [fpa_pkg::DW-1:0]   out_value,
   output logic                     out_flag,
   output logic [1:0]               out_status
);

   localparam int DW = fpa_pkg::DW;
   localparam int NW = fpa_pkg::NW;
   localparam int PW = fpa_pkg::PW;
   localparam int F  = fpa_pkg::FRAC_BITS;
   localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

   logic                 rnd_valid_ff;
   fpa_pkg::res_type     rnd_ff;
   fpa_pkg::res_type     rnd_in;
   logic                 valid_ff;
   logic [DW-1:0]        value_ff;
   logic                 flag_ff;
   logic [1:0]           status_ff;
   logic [DW-1:0]        value_in;
   logic [1:0]           status_in;
   logic [PW-1:0]        pabs;
   logic                 up;
   logic [NW:0]          qr;

   always_comb begin
      pabs = in_item.prod[PW-1] ? PW'(-in_item.prod) : in_item.prod;
      // round half away from zero: remainder at least half the divisor
      up   = {in_item.rem, 1'b0} >= {1'b0, in_item.den};
      qr   = {1'b0, in_item.quo} + (NW+1)'(up);
      rnd_in        = '0;
      rnd_in.op     = in_item.op;
      rnd_in.value  = in_item.value;
      rnd_in.flag   = in_item.flag;
      rnd_in.status = in_item.status;
      if (in_item.op == fpa_pkg::OP_MUL) begin
         rnd_in.mag = (pabs + HALF) >> F;
         rnd_in.neg = in_item.prod[PW-1];
      end else begin
         rnd_in.mag = {{(PW-NW-1){1'b0}}, qr};
         rnd_in.neg = in_item.neg;
      end
   end

   always_comb begin
      value_in  = rnd_ff.value;
      status_in = rnd_ff.status;
      if (rnd_ff.op == fpa_pkg::OP_MUL ||
          (rnd_ff.op == fpa_pkg::OP_DIV && rnd_ff.status == fpa_pkg::ST_OK)) begin
         if (rnd_ff.neg) begin
            if (rnd_ff.mag > {{(PW-DW){1'b0}}, fpa_pkg::MIN_VAL}) begin
               status_in = fpa_pkg::ST_OVF;
               value_in  = fpa_pkg::MIN_VAL;
            end else begin
               value_in = DW'(-rnd_ff.mag);
            end
         end else begin
            if (rnd_ff.mag > {{(PW-DW){1'b0}}, fpa_pkg::MAX_VAL}) begin
               status_in = fpa_pkg::ST_OVF;
               value_in  = fpa_pkg::MAX_VAL;
            end else begin
               value_in = rnd_ff.mag[DW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (en) begin
         rnd_valid_ff <= in_valid;
         valid_ff     <= rnd_valid_ff;
      end
      if (en) begin
         rnd_ff    <= rnd_in;
         value_ff  <= value_in;
         flag_ff   <= rnd_ff.flag;
         status_ff <= status_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_value  = value_ff;
   assign out_flag   = flag_ff;
   assign out_status = status_ff;

endmodule

/* rtl/fixed_point_alu.sv */
// fixed_point_alu: top level, a front stage, a chain of division cells,
// a rounding back end and an output register with skid stage
// depends on fpa_pkg, fpa_front, fpa_cell, fpa_back
//
// usage:
//   requests come in on req_*: tuser carries the opcode, tdata the two raw
//   Q23.8 operands. every request gives exactly one response on rsp_*:
//   the raw value and comparison flag in tdata, the status in tuser.
//   a request passes FRAC_BITS + 36 registers (44 at 8 fractional bits),
//   the same for every opcode, so responses leave in request order. one
//   request per cycle is taken back to back while req_tready is high.
//   the length is set by the divider: one cell per quotient bit, 40 cells.
//   when the receiver stalls, the output register holds its response and
//   one more lands in the skid stage; the whole pipe then freezes and
//   req_tready drops until the skid stage drains.
//   reset clears all valid bits; no request is in flight afterwards.
module fixed_point_alu (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // operand_a[31:0], operand_b[63:32]
   input  logic [3:0]    req_tuser,   // op[3:0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata,   // value[31:0], flag[32], zero fill[39:33]
   output logic [1:0]    rsp_tuser    // status[1:0]
);

   localparam int DW = fpa_pkg::DW;
   localparam int NW = fpa_pkg::NW;

   logic                 en;
   logic                 chain_valid [NW+1];
   fpa_pkg::item_type    chain_item  [NW+1];
   logic                 pipe_valid;
   logic [DW-1:0]        pipe_value;
   logic                 pipe_flag;
   logic [1:0]           pipe_status;

   logic                 out_valid_ff;
   logic [DW-1:0]        out_value_ff;
   logic                 out_flag_ff;
   logic [1:0]           out_status_ff;
   logic                 skid_valid_ff;
   logic [DW-1:0]        skid_value_ff;
   logic                 skid_flag_ff;
   logic [1:0]           skid_status_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_op     (req_tuser),
      .in_a      (req_tdata[DW-1:0]),
      .in_b      (req_tdata[2*DW-1:DW]),
      .out_valid (chain_valid[0]),
      .out_item  (chain_item[0])
   );

   for (genvar i = 0; i < NW; i++) begin : g_cell
      fpa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_valid[i]),
         .in_item   (chain_item[i]),
         .out_valid (chain_valid[i+1]),
         .out_item  (chain_item[i+1])
      );
   end

   fpa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (chain_valid[NW]),
      .in_item    (chain_item[NW]),
      .out_valid  (pipe_valid),
      .out_value  (pipe_value),
      .out_flag   (pipe_flag),
      .out_status (pipe_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (pipe_valid) begin
         if (out_valid_ff && !rsp_tready) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end

      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_value_ff  <= skid_value_ff;
            out_flag_ff   <= skid_flag_ff;
            out_status_ff <= skid_status_ff;
         end
      end else if (pipe_valid) begin
         if (out_valid_ff && !rsp_tready) begin
            skid_value_ff  <= pipe_value;
            skid_flag_ff   <= pipe_flag;
            skid_status_ff <= pipe_status;
         end else begin
            out_value_ff  <= pipe_value;
            out_flag_ff   <= pipe_flag;
            out_status_ff <= pipe_status;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_flag_ff, out_value_ff};
   assign rsp_tuser  = out_status_ff;

endmodule
